// ===== hw/rtl/sbb_pkg.sv =====
// Shared types, constants and a helper function for the separable box blur.
package sbb_pkg;

  localparam int CFG_W = 11;
  localparam int CH_W = 8;
  localparam int HS_W = 11;
  localparam int SUM_W = 13;
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP = 16'd41944;
  localparam int RECIP_SHIFT = 20;
  localparam logic [SUM_W-1:0] ROUND = 13'd12;
  localparam int TAPS = 5;
  localparam int FIFO_DEPTH = 8;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pix_t;

  typedef logic [HS_W-1:0] hchan_t;

  typedef struct packed {
    hchan_t blue;
    hchan_t green;
    hchan_t red;
  } hsum_t;

  typedef logic [2:0] bank_t;

  typedef struct packed {
    logic valid;
    logic last;
    bank_t [TAPS-1:0] banks;
  } rd_ctl_t;

  // Remainder modulo 5, using 16 == 1 (mod 5) to fold nibbles.
  function automatic bank_t mod5(input logic [15:0] v);
    logic [5:0] s1;
    logic [4:0] s2;
    s1 = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
    s2 = 5'(s1[3:0]) + 5'(s1[5:4]);
    if (s2 >= 5'd10) begin
      s2 = s2 - 5'd10;
    end
    if (s2 >= 5'd5) begin
      s2 = s2 - 5'd5;
    end
    return bank_t'(s2);
  endfunction

endpackage

// ===== hw/rtl/separable_box_blur_5tap.sv =====
// Top level of the 5x5 separable box blur with clamp-to-edge borders.
// Path: a released result passes the read-control register, the line-store read, the sum and the
// product registers into the output queue; the read waits while the line store takes edge sums.
// Throughput: one transaction per cycle, except that the last pixel of a row holds the input
// while the edge sums are written, and the input also waits while eight released results have
// not yet been taken.
// Reset: synchronous; clears positions, pipeline and output queue, sets 640 x 480.
// The line store is five RAM banks, one per row of the ring, and needs no clearing pass.
module separable_box_blur_5tap #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out, green_out, blue_out
  output logic        m_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WA = $clog2(MAX_WIDTH + 1);
  localparam int WB = $clog2(MAX_HEIGHT + 1);
  localparam int WM = (WA > WB) ? WA : WB;
  localparam int WW = (WM > sbb_pkg::CFG_W) ? WM : sbb_pkg::CFG_W;
  localparam int PW = RW + WW + 1;
  localparam int NT = sbb_pkg::TAPS;
  localparam int FD = sbb_pkg::FIFO_DEPTH;
  localparam int FAW = $clog2(FD);
  localparam int CNW = $clog2(FD + 1);
  localparam int PRW = sbb_pkg::SUM_W + sbb_pkg::RECIP_W;
  localparam int OW = 3 * sbb_pkg::CH_W + 1;

  logic [sbb_pkg::CFG_W-1:0] cfg_w;
  logic [sbb_pkg::CFG_W-1:0] cfg_h;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] h_eff;

  sbb_pkg::pix_t [NT-1:0] win;
  sbb_pkg::pix_t [NT-1:0] win_next;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  sbb_pkg::bank_t in_bank;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  sbb_pkg::bank_t out_bank;
  logic draining;

  logic [1:0] ext_left;
  logic [1:0] ext_d;
  logic [CW-1:0] ext_col;
  sbb_pkg::bank_t wbank;

  sbb_pkg::rd_ctl_t e_ctl;
  logic [CW-1:0] e_col;
  sbb_pkg::rd_ctl_t r1_ctl;
  sbb_pkg::hsum_t rdata [NT];

  logic [sbb_pkg::SUM_W-1:0] s2_sum [3];
  logic s2_valid;
  logic s2_last;
  logic [PRW-1:0] s3_prod [3];
  logic s3_valid;
  logic s3_last;

  logic [OW-1:0] fifo_mem [FD];
  logic [FAW-1:0] wptr;
  logic [FAW-1:0] rptr;
  logic [CNW-1:0] fcnt;
  logic [CNW-1:0] credit;

  logic acc;
  logic is_drain;
  sbb_pkg::pix_t pix_in;
  logic last_in_col;
  logic last_in_row;
  logic [1:0] d_first;
  logic st_we_acc;
  logic [CW-1:0] st_col_acc;
  logic [1:0] ext_cnt;
  logic [RW+WW-1:0] row_base;
  logic [PW-1:0] pos;
  logic [WW+1:0] lag;
  logic emit;
  logic [CW-1:0] o_col;
  logic [RW-1:0] o_row;
  sbb_pkg::bank_t o_bank;
  logic o_last_col;
  logic o_last_row;
  sbb_pkg::bank_t hm1;
  sbb_pkg::bank_t [NT-1:0] banks;

  logic ram_we;
  logic [CW-1:0] ram_waddr;
  sbb_pkg::hsum_t ram_wdata;
  sbb_pkg::bank_t ram_wbank;
  logic issue;
  logic [sbb_pkg::SUM_W-1:0] vsum [3];
  logic pop;

  function automatic sbb_pkg::hsum_t tap_sum(input sbb_pkg::pix_t [NT-1:0] w,
                                             input logic [1:0] d);
    sbb_pkg::hsum_t s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < NT; i++) begin
      t = 3'(d) + 3'(i);
      if (t > 3'd4) begin
        t = 3'd4;
      end
      s.red = s.red + sbb_pkg::HS_W'(w[t].red);
      s.green = s.green + sbb_pkg::HS_W'(w[t].green);
      s.blue = s.blue + sbb_pkg::HS_W'(w[t].blue);
    end
    return s;
  endfunction

  function automatic sbb_pkg::bank_t bank_add(input sbb_pkg::bank_t b, input logic [2:0] k);
    logic [3:0] s;
    s = 4'(b) + 4'(k) + 4'd3;
    if (s >= 4'd10) begin
      s = s - 4'd10;
    end else if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return sbb_pkg::bank_t'(s);
  endfunction

  always_comb begin
    if (cfg_w == '0) begin
      w_eff = WW'(1);
    end else if (WW'(cfg_w) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w);
    end
    if (cfg_h == '0) begin
      h_eff = WW'(1);
    end else if (WW'(cfg_h) > WW'(MAX_HEIGHT)) begin
      h_eff = WW'(MAX_HEIGHT);
    end else begin
      h_eff = WW'(cfg_h);
    end
  end

  assign s_tready = (ext_left == 2'd0) && (credit < CNW'(FD));
  assign acc = s_tvalid && s_tready;
  assign is_drain = (s_tuser == sbb_pkg::OP_DRAIN);
  assign pix_in = sbb_pkg::pix_t'(s_tdata);

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      if (in_col == '0 || i == NT - 1) begin
        win_next[i] = pix_in;
      end else begin
        win_next[i] = win[i+1];
      end
    end
  end

  always_comb begin
    last_in_col = ((WW+1)'(in_col) + (WW+1)'(1)) >= (WW+1)'(w_eff);
    last_in_row = ((WW+1)'(in_row) + (WW+1)'(1)) >= (WW+1)'(h_eff);
    if (in_col >= CW'(2)) begin
      d_first = 2'd0;
      st_col_acc = in_col - CW'(2);
    end else if (in_col == CW'(1)) begin
      d_first = 2'd1;
      st_col_acc = '0;
    end else begin
      d_first = 2'd2;
      st_col_acc = '0;
    end
    st_we_acc = (in_col >= CW'(2)) || last_in_col;
    ext_cnt = last_in_col ? (2'd2 - d_first) : 2'd0;

    row_base = in_row * w_eff;
    pos = PW'(row_base) + PW'(in_col);
    if (w_eff >= WW'(3)) begin
      lag = ((WW+2)'(w_eff) << 1) + (WW+2)'(2);
    end else if (w_eff == WW'(2)) begin
      lag = (WW+2)'(5);
    end else begin
      lag = (WW+2)'(2);
    end
    emit = is_drain ? draining : (pos >= PW'(lag));

    if (!is_drain && draining) begin
      o_col = '0;
      o_row = '0;
      o_bank = '0;
    end else begin
      o_col = out_col;
      o_row = out_row;
      o_bank = out_bank;
    end
    o_last_col = ((WW+1)'(o_col) + (WW+1)'(1)) >= (WW+1)'(w_eff);
    o_last_row = ((WW+1)'(o_row) + (WW+1)'(1)) >= (WW+1)'(h_eff);

    hm1 = sbb_pkg::mod5(16'(h_eff - WW'(1)));
    for (int k = 0; k < NT; k++) begin
      if (((WW+1)'(o_row) + (WW+1)'(k)) < (WW+1)'(2)) begin
        banks[k] = '0;
      end else if (((WW+1)'(o_row) + (WW+1)'(k)) > ((WW+1)'(h_eff) + (WW+1)'(1))) begin
        banks[k] = hm1;
      end else begin
        banks[k] = bank_add(o_bank, 3'(k));
      end
    end
  end

  always_comb begin
    if (ext_left != 2'd0) begin
      ram_we = 1'b1;
      ram_waddr = ext_col;
      ram_wdata = tap_sum(win, ext_d);
      ram_wbank = wbank;
    end else begin
      ram_we = acc && !is_drain && st_we_acc;
      ram_waddr = st_col_acc;
      ram_wdata = tap_sum(win_next, d_first);
      ram_wbank = in_bank;
    end
  end

  assign issue = e_ctl.valid && (ext_left == 2'd0);

  for (genvar g = 0; g < NT; g++) begin : g_bank
    sbb_ram #(
      .WIDTH($bits(sbb_pkg::hsum_t)),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we && (ram_wbank == sbb_pkg::bank_t'(g))),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (issue),
      .raddr (e_col),
      .rdata (rdata[g])
    );
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vsum[c] = sbb_pkg::ROUND;
    end
    for (int k = 0; k < NT; k++) begin
      vsum[0] = vsum[0] + sbb_pkg::SUM_W'(rdata[r1_ctl.banks[k]].red);
      vsum[1] = vsum[1] + sbb_pkg::SUM_W'(rdata[r1_ctl.banks[k]].green);
      vsum[2] = vsum[2] + sbb_pkg::SUM_W'(rdata[r1_ctl.banks[k]].blue);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= sbb_pkg::CFG_W'(640);
      cfg_h <= sbb_pkg::CFG_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbb_pkg::REG_WIDTH: cfg_w <= cfg_data;
        sbb_pkg::REG_HEIGHT: cfg_h <= cfg_data;
        default: cfg_w <= cfg_w;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !is_drain) begin
      win <= win_next;
    end
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
      in_bank <= '0;
      out_col <= '0;
      out_row <= '0;
      out_bank <= '0;
      draining <= 1'b0;
      ext_left <= '0;
      e_ctl <= '0;
    end else begin
      if (ext_left != 2'd0) begin
        ext_left <= ext_left - 2'd1;
        ext_d <= ext_d + 2'd1;
        ext_col <= ext_col + CW'(1);
      end
      if (acc) begin
        e_ctl.valid <= emit;
      end else if (issue) begin
        e_ctl.valid <= 1'b0;
      end
      if (acc) begin
        e_ctl.last <= o_last_col && o_last_row;
        e_ctl.banks <= banks;
        e_col <= o_col;
        if (emit) begin
          if (o_last_col) begin
            out_col <= '0;
            if (o_last_row) begin
              out_row <= '0;
              out_bank <= '0;
            end else begin
              out_row <= o_row + RW'(1);
              out_bank <= bank_add(o_bank, 3'd3);
            end
          end else begin
            out_col <= o_col + CW'(1);
            out_row <= o_row;
            out_bank <= o_bank;
          end
        end else begin
          out_col <= o_col;
          out_row <= o_row;
          out_bank <= o_bank;
        end
        if (is_drain) begin
          draining <= draining && !(emit && o_last_col && o_last_row);
        end else begin
          draining <= last_in_col && last_in_row;
          ext_left <= ext_cnt;
          ext_d <= d_first + 2'd1;
          ext_col <= st_col_acc + CW'(1);
          wbank <= in_bank;
          if (last_in_col) begin
            in_col <= '0;
            if (last_in_row) begin
              in_row <= '0;
              in_bank <= '0;
            end else begin
              in_row <= in_row + RW'(1);
              in_bank <= bank_add(in_bank, 3'd3);
            end
          end else begin
            in_col <= in_col + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_ctl <= '0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      r1_ctl.valid <= issue;
      r1_ctl.last <= e_ctl.last;
      r1_ctl.banks <= e_ctl.banks;
      s2_valid <= r1_ctl.valid;
      s3_valid <= s2_valid;
    end
    s2_last <= r1_ctl.last;
    s3_last <= s2_last;
    for (int c = 0; c < 3; c++) begin
      s2_sum[c] <= vsum[c];
      s3_prod[c] <= PRW'(s2_sum[c]) * PRW'(sbb_pkg::RECIP);
    end
  end

  assign pop = m_tvalid && m_tready;
  assign m_tvalid = (fcnt != '0);
  assign m_tdata = fifo_mem[rptr][3*sbb_pkg::CH_W-1:0];
  assign m_tlast = fifo_mem[rptr][OW-1];

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      fifo_mem[wptr] <= {s3_last,
                         s3_prod[2][sbb_pkg::RECIP_SHIFT+sbb_pkg::CH_W-1:sbb_pkg::RECIP_SHIFT],
                         s3_prod[1][sbb_pkg::RECIP_SHIFT+sbb_pkg::CH_W-1:sbb_pkg::RECIP_SHIFT],
                         s3_prod[0][sbb_pkg::RECIP_SHIFT+sbb_pkg::CH_W-1:sbb_pkg::RECIP_SHIFT]};
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fcnt <= '0;
      credit <= '0;
    end else begin
      if (s3_valid) begin
        wptr <= wptr + FAW'(1);
      end
      if (pop) begin
        rptr <= rptr + FAW'(1);
      end
      fcnt <= fcnt + CNW'(s3_valid) - CNW'(pop);
      credit <= credit + CNW'(acc && emit) - CNW'(pop);
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CNW'(FD))
    else $error("result credit exceeds the output queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fcnt <= credit)
    else $error("output queue holds more results than were released");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (fcnt < CNW'(FD)) || pop)
    else $error("output queue overflow");

  a_edge_writes_block_input: assert property (@(posedge clk) disable iff (rst)
    (ext_left != 2'd0) |-> !s_tready && !issue)
    else $error("input taken or read issued during edge writes");

endmodule

// ===== hw/rtl/sbb_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
module sbb_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
